>>> design/ggh_pkg.sv
// ----------------------------------------------------------------------------
// Go-to-goal heading controller package
// Shared widths, constants, register codes, the CORDIC arctangent table and
// the structs that travel between the controller's modules.
// ----------------------------------------------------------------------------
package ggh_pkg;

   // Fixed field widths.
   localparam int HEAD_WIDTH      = 15;
   localparam int SPEED_WIDTH     = 16;
   localparam int RATE_WIDTH      = 16;
   localparam int GAIN_WIDTH      = 16;
   localparam int ATOL_WIDTH      = 15;
   localparam int GTOL_WIDTH      = 31;

   // Angle accumulator in Q.29 and the derived datapath widths.
   localparam int Z_WIDTH         = 34;
   localparam int Z_SHIFT         = 17;
   localparam int BEAR_WIDTH      = Z_WIDTH - Z_SHIFT;
   localparam int ERR_WIDTH       = BEAR_WIDTH + 1;
   localparam int PROD_WIDTH      = GAIN_WIDTH + 1 + ERR_WIDTH;
   localparam int TURN_FRAC       = 12;
   localparam int TURN_WIDTH      = PROD_WIDTH - TURN_FRAC;
   localparam int MAG_WIDTH       = RATE_WIDTH + 1;
   localparam int CORDIC_MAX      = 24;

   localparam logic signed [Z_WIDTH-1:0]    PI_Q29     = 34'sd1686629713;
   localparam logic signed [Z_WIDTH-1:0]    Z_ROUND    = 34'sd65536;
   localparam logic signed [PROD_WIDTH-1:0] TURN_ROUND = 35'sd2048;
   localparam logic signed [TURN_WIDTH-1:0] TURN_MAX   = 23'sd32767;
   localparam logic signed [TURN_WIDTH-1:0] TURN_MIN   = -23'sd32768;

   // Configuration port.
   localparam int CSR_ADDR_WIDTH  = 4;
   localparam int CSR_DATA_WIDTH  = 32;

   typedef enum logic [1:0] {
      REG_TURN_GAIN       = 2'd0,
      REG_ANGLE_TOLERANCE = 2'd1,
      REG_GOAL_TOLERANCE  = 2'd2,
      REG_FORWARD_SPEED   = 2'd3
   } ggh_reg_type;

   localparam logic [GAIN_WIDTH-1:0]  RST_TURN_GAIN       = 16'd1229;
   localparam logic [ATOL_WIDTH-1:0]  RST_ANGLE_TOLERANCE = 15'd205;
   localparam logic [GTOL_WIDTH-1:0]  RST_GOAL_TOLERANCE  = 31'd6554;
   localparam logic [SPEED_WIDTH-1:0] RST_FORWARD_SPEED   = 16'd819;

   typedef struct packed {
      logic [GAIN_WIDTH-1:0]  turn_gain;
      logic [ATOL_WIDTH-1:0]  angle_tolerance;
      logic [GTOL_WIDTH-1:0]  goal_tolerance;
      logic [SPEED_WIDTH-1:0] forward_speed;
   } ggh_cfg_type;

   // Side information that rides along with each word through the cells.
   typedef struct packed {
      logic                         arrived;
      logic                         zero_vec;
      logic signed [HEAD_WIDTH-1:0] heading;
   } ggh_tag_type;

   // atan(2^-i) in Q.29.
   function automatic logic signed [Z_WIDTH-1:0] ggh_atan_q29(input int idx);
      logic signed [Z_WIDTH-1:0] val;
      case (idx)
         0:       val = 34'sd421657428;
         1:       val = 34'sd248918915;
         2:       val = 34'sd131521918;
         3:       val = 34'sd66762579;
         4:       val = 34'sd33510843;
         5:       val = 34'sd16771758;
         6:       val = 34'sd8387925;
         7:       val = 34'sd4194219;
         8:       val = 34'sd2097141;
         9:       val = 34'sd1048575;
         10:      val = 34'sd524288;
         11:      val = 34'sd262144;
         12:      val = 34'sd131072;
         13:      val = 34'sd65536;
         14:      val = 34'sd32768;
         15:      val = 34'sd16384;
         16:      val = 34'sd8192;
         17:      val = 34'sd4096;
         18:      val = 34'sd2048;
         19:      val = 34'sd1024;
         20:      val = 34'sd512;
         21:      val = 34'sd256;
         22:      val = 34'sd128;
         23:      val = 34'sd64;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> design/ggh_req_if.sv
// ----------------------------------------------------------------------------
// Go-to-goal request channel
// Valid/ready channel carrying one pose word: target, robot position, heading.
// ----------------------------------------------------------------------------
interface ggh_req_if #(
   parameter int POS_WIDTH = 32
) ();
   import ggh_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [POS_WIDTH-1:0]  target_x;
   logic signed [POS_WIDTH-1:0]  target_y;
   logic signed [POS_WIDTH-1:0]  robot_x;
   logic signed [POS_WIDTH-1:0]  robot_y;
   logic signed [HEAD_WIDTH-1:0] heading;

   modport source (
      output valid, target_x, target_y, robot_x, robot_y, heading,
      input  ready
   );

   modport sink (
      input  valid, target_x, target_y, robot_x, robot_y, heading,
      output ready
   );

endinterface

>>> design/ggh_rsp_if.sv
// ----------------------------------------------------------------------------
// Go-to-goal response channel
// Valid/ready channel carrying one command word: speed, turn rate, arrival.
// ----------------------------------------------------------------------------
interface ggh_rsp_if ();
   import ggh_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [SPEED_WIDTH-1:0]       linear_speed;
   logic signed [RATE_WIDTH-1:0] angular_rate;
   logic                         arrived;

   modport source (
      output valid, linear_speed, angular_rate, arrived,
      input  ready
   );

   modport sink (
      input  valid, linear_speed, angular_rate, arrived,
      output ready
   );

endinterface

>>> design/go_to_goal_heading_controller_top.sv
// ----------------------------------------------------------------------------
// Go-to-goal heading controller
// Bearing to goal by pipelined CORDIC, proportional turn command, arrival test.
// ----------------------------------------------------------------------------
// The controller takes one pose word per clock while the response port keeps
// up, and returns one command word per pose word, in order. Registered stages
// form the position difference, then the arrival test and the quadrant fold,
// a chain of CORDIC cells finds the bearing, and registered stages then form
// the heading error, the gain product and the rounded, saturated command.
// Every stage carries its own valid bit and hands its word on as soon as the
// next stage has room, so a stalled response port holds only the words behind
// it and bubbles close up. Registers sit at byte addresses 0 (turn_gain),
// 4 (angle_tolerance), 8 (goal_tolerance) and 12 (forward_speed); write them
// only while no word is in flight.
module go_to_goal_heading_controller_top #(
   parameter int POS_WIDTH     = 32,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   ggh_req_if.sink                             req,
   ggh_rsp_if.source                           rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ggh_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [ggh_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [ggh_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import ggh_pkg::*;

   localparam int DW = POS_WIDTH + 1;
   localparam int CW = POS_WIDTH + 3;
   localparam int AW = (DW > GTOL_WIDTH) ? DW : GTOL_WIDTH;
   localparam int NS = CORDIC_STAGES;

   ggh_cfg_type cfg;

   ggh_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // ---------------- difference stage ----------------
   logic                         f1_valid_ff;
   logic                         f1_ready;
   logic signed [DW-1:0]         f1_dx_ff, f1_dx_in;
   logic signed [DW-1:0]         f1_dy_ff, f1_dy_in;
   logic signed [HEAD_WIDTH-1:0] f1_head_ff;
   logic                         f2_ready;

   assign f1_ready  = !f1_valid_ff || f2_ready;
   assign req.ready = f1_ready;
   assign f1_dx_in  = DW'(req.target_x) - DW'(req.robot_x);
   assign f1_dy_in  = DW'(req.target_y) - DW'(req.robot_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (f1_ready) begin
         f1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (f1_ready && req.valid) begin
         f1_dx_ff   <= f1_dx_in;
         f1_dy_ff   <= f1_dy_in;
         f1_head_ff <= req.heading;
      end
   end

   // ---------------- arrival test and quadrant fold ----------------
   logic                      f2_valid_ff;
   logic signed [CW-1:0]      f2_x_ff, f2_x_in;
   logic signed [CW-1:0]      f2_y_ff, f2_y_in;
   logic signed [Z_WIDTH-1:0] f2_z_ff, f2_z_in;
   ggh_tag_type               f2_tag_ff, f2_tag_in;
   logic [DW-1:0]             abs_dx, abs_dy;
   logic signed [CW-1:0]      dx_w, dy_w;
   logic                      dx_neg;
   logic                      c_ready [0:NS];

   assign f2_ready = !f2_valid_ff || c_ready[0];
   assign dx_neg   = f1_dx_ff[DW-1];
   assign dx_w     = CW'(f1_dx_ff);
   assign dy_w     = CW'(f1_dy_ff);
   assign abs_dx   = dx_neg ? DW'(-f1_dx_ff) : DW'(f1_dx_ff);
   assign abs_dy   = f1_dy_ff[DW-1] ? DW'(-f1_dy_ff) : DW'(f1_dy_ff);

   always_comb begin
      f2_tag_in.heading  = f1_head_ff;
      f2_tag_in.zero_vec = (f1_dx_ff == '0) && (f1_dy_ff == '0);
      f2_tag_in.arrived  = (AW'(abs_dx) < AW'(cfg.goal_tolerance)) &&
                           (AW'(abs_dy) < AW'(cfg.goal_tolerance));
      // A vector in the left half plane is turned by pi first.
      if (dx_neg) begin
         f2_x_in = -dx_w;
         f2_y_in = -dy_w;
         f2_z_in = f1_dy_ff[DW-1] ? -PI_Q29 : PI_Q29;
      end else begin
         f2_x_in = dx_w;
         f2_y_in = dy_w;
         f2_z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else if (f2_ready) begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f2_ready && f1_valid_ff) begin
         f2_x_ff   <= f2_x_in;
         f2_y_ff   <= f2_y_in;
         f2_z_ff   <= f2_z_in;
         f2_tag_ff <= f2_tag_in;
      end
   end

   // ---------------- CORDIC cell chain ----------------
   logic                      c_valid [0:NS];
   logic signed [CW-1:0]      c_x     [0:NS];
   logic signed [CW-1:0]      c_y     [0:NS];
   logic signed [Z_WIDTH-1:0] c_z     [0:NS];
   ggh_tag_type               c_tag   [0:NS];
   logic                      b1_ready;

   assign c_valid[0] = f2_valid_ff;
   assign c_x[0]     = f2_x_ff;
   assign c_y[0]     = f2_y_ff;
   assign c_z[0]     = f2_z_ff;
   assign c_tag[0]   = f2_tag_ff;
   assign c_ready[NS] = b1_ready;

   for (genvar i = 0; i < NS; i++) begin : g_cell
      ggh_cordic_cell #(
         .STAGE    (i),
         .XY_WIDTH (CW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (c_valid[i]),
         .up_ready   (c_ready[i]),
         .x_up       (c_x[i]),
         .y_up       (c_y[i]),
         .z_up       (c_z[i]),
         .tag_up     (c_tag[i]),
         .down_valid (c_valid[i+1]),
         .down_ready (c_ready[i+1]),
         .x_down     (c_x[i+1]),
         .y_down     (c_y[i+1]),
         .z_down     (c_z[i+1]),
         .tag_down   (c_tag[i+1])
      );
   end

   // ---------------- bearing and heading error ----------------
   logic                         b1_valid_ff;
   logic signed [ERR_WIDTH-1:0]  b1_err_ff, b1_err_in;
   logic                         b1_arr_ff;
   logic signed [Z_WIDTH-1:0]    z_sum;
   logic signed [BEAR_WIDTH-1:0] bearing;
   logic                         b2_ready;

   assign b1_ready  = !b1_valid_ff || b2_ready;
   assign z_sum     = c_z[NS] + Z_ROUND;
   assign bearing   = c_tag[NS].zero_vec ? '0 : z_sum[Z_WIDTH-1:Z_SHIFT];
   assign b1_err_in = ERR_WIDTH'(bearing) - ERR_WIDTH'(c_tag[NS].heading);

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else if (b1_ready) begin
         b1_valid_ff <= c_valid[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (b1_ready && c_valid[NS]) begin
         b1_err_ff <= b1_err_in;
         b1_arr_ff <= c_tag[NS].arrived;
      end
   end

   // ---------------- gain product ----------------
   logic                          b2_valid_ff;
   logic signed [PROD_WIDTH-1:0]  b2_prod_ff, b2_prod_in;
   logic                          b2_arr_ff;
   logic                          b3_ready;

   assign b2_ready   = !b2_valid_ff || b3_ready;
   assign b2_prod_in = $signed({1'b0, cfg.turn_gain}) * b1_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else if (b2_ready) begin
         b2_valid_ff <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b2_ready && b1_valid_ff) begin
         b2_prod_ff <= b2_prod_in;
         b2_arr_ff  <= b1_arr_ff;
      end
   end

   // ---------------- rounding, saturation and decision ----------------
   logic                          out_valid_ff;
   logic [SPEED_WIDTH-1:0]        out_lin_ff, out_lin_in;
   logic signed [RATE_WIDTH-1:0]  out_ang_ff, out_ang_in;
   logic                          out_arr_ff;
   logic signed [PROD_WIDTH-1:0]  prod_rnd;
   logic signed [TURN_WIDTH-1:0]  turn_full;
   logic signed [RATE_WIDTH-1:0]  turn_sat;
   logic signed [MAG_WIDTH-1:0]   turn_ext;
   logic [MAG_WIDTH-1:0]          turn_mag;

   assign b3_ready  = !out_valid_ff || rsp.ready;
   assign prod_rnd  = b2_prod_ff + TURN_ROUND;
   assign turn_full = prod_rnd[PROD_WIDTH-1:TURN_FRAC];

   always_comb begin
      if (turn_full > TURN_MAX) begin
         turn_sat = TURN_MAX[RATE_WIDTH-1:0];
      end else if (turn_full < TURN_MIN) begin
         turn_sat = TURN_MIN[RATE_WIDTH-1:0];
      end else begin
         turn_sat = turn_full[RATE_WIDTH-1:0];
      end
      turn_ext = MAG_WIDTH'(turn_sat);
      turn_mag = turn_ext[MAG_WIDTH-1] ? MAG_WIDTH'(-turn_ext) : MAG_WIDTH'(turn_ext);

      out_lin_in = '0;
      out_ang_in = '0;
      if (!b2_arr_ff) begin
         if (turn_mag < MAG_WIDTH'(cfg.angle_tolerance)) begin
            out_lin_in = cfg.forward_speed;
         end else begin
            out_ang_in = turn_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (b3_ready) begin
         out_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b3_ready && b2_valid_ff) begin
         out_lin_ff <= out_lin_in;
         out_ang_ff <= out_ang_in;
         out_arr_ff <= b2_arr_ff;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.linear_speed = out_lin_ff;
   assign rsp.angular_rate = out_ang_ff;
   assign rsp.arrived      = out_arr_ff;

   // ---------------- assertions ----------------
   logic signed [MAG_WIDTH-1:0] rsp_ang_ext;
   logic [MAG_WIDTH-1:0]        rsp_ang_mag;

   assign rsp_ang_ext = MAG_WIDTH'(out_ang_ff);
   assign rsp_ang_mag = rsp_ang_ext[MAG_WIDTH-1] ? MAG_WIDTH'(-rsp_ang_ext)
                                                 : MAG_WIDTH'(rsp_ang_ext);

   // An arrival word commands a full stop.
   a_arrived_stops: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.arrived |-> rsp.linear_speed == '0 && rsp.angular_rate == '0)
      else $error("arrival word carries a nonzero command");

   // The robot either drives or turns, never both.
   a_drive_or_turn: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.linear_speed == '0 || rsp.angular_rate == '0)
      else $error("speed and turn rate both nonzero");

   // A turn command is only issued at or above the angle tolerance.
   a_turn_above_tol: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.angular_rate != '0 |->
         rsp_ang_mag >= MAG_WIDTH'(cfg.angle_tolerance))
      else $error("turn command below angle tolerance");

endmodule

>>> design/ggh_csr.sv
// ----------------------------------------------------------------------------
// Go-to-goal configuration registers
// APB-style register file holding gain, tolerances and forward speed.
// ----------------------------------------------------------------------------
module ggh_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ggh_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [ggh_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [ggh_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready,
   output ggh_pkg::ggh_cfg_type                cfg
);
   import ggh_pkg::*;

   ggh_cfg_type cfg_ff;
   ggh_cfg_type cfg_in;
   ggh_reg_type reg_idx;
   logic        wr_en;

   assign reg_idx = ggh_reg_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TURN_GAIN:       cfg_in.turn_gain       = pwdata[GAIN_WIDTH-1:0];
            REG_ANGLE_TOLERANCE: cfg_in.angle_tolerance = pwdata[ATOL_WIDTH-1:0];
            REG_GOAL_TOLERANCE:  cfg_in.goal_tolerance  = pwdata[GTOL_WIDTH-1:0];
            REG_FORWARD_SPEED:   cfg_in.forward_speed   = pwdata[SPEED_WIDTH-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TURN_GAIN:       prdata = CSR_DATA_WIDTH'(cfg_ff.turn_gain);
         REG_ANGLE_TOLERANCE: prdata = CSR_DATA_WIDTH'(cfg_ff.angle_tolerance);
         REG_GOAL_TOLERANCE:  prdata = CSR_DATA_WIDTH'(cfg_ff.goal_tolerance);
         REG_FORWARD_SPEED:   prdata = CSR_DATA_WIDTH'(cfg_ff.forward_speed);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.turn_gain       <= RST_TURN_GAIN;
         cfg_ff.angle_tolerance <= RST_ANGLE_TOLERANCE;
         cfg_ff.goal_tolerance  <= RST_GOAL_TOLERANCE;
         cfg_ff.forward_speed   <= RST_FORWARD_SPEED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/ggh_cordic_cell.sv
// ----------------------------------------------------------------------------
// Go-to-goal CORDIC cell
// One vectoring micro-rotation with its own pipeline register and handshake.
// ----------------------------------------------------------------------------
module ggh_cordic_cell #(
   parameter int STAGE    = 0,
   parameter int XY_WIDTH = 35
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               up_valid,
   output logic                               up_ready,
   input  logic signed [XY_WIDTH-1:0]         x_up,
   input  logic signed [XY_WIDTH-1:0]         y_up,
   input  logic signed [ggh_pkg::Z_WIDTH-1:0] z_up,
   input  ggh_pkg::ggh_tag_type               tag_up,
   output logic                               down_valid,
   input  logic                               down_ready,
   output logic signed [XY_WIDTH-1:0]         x_down,
   output logic signed [XY_WIDTH-1:0]         y_down,
   output logic signed [ggh_pkg::Z_WIDTH-1:0] z_down,
   output ggh_pkg::ggh_tag_type               tag_down
);
   import ggh_pkg::*;

   localparam logic signed [Z_WIDTH-1:0] ATAN = ggh_atan_q29(STAGE);

   logic                       valid_ff, valid_in;
   logic signed [XY_WIDTH-1:0] x_ff, x_in;
   logic signed [XY_WIDTH-1:0] y_ff, y_in;
   logic signed [Z_WIDTH-1:0]  z_ff, z_in;
   ggh_tag_type                tag_ff;
   logic                       y_pos;
   logic                       load;

   assign up_ready = !valid_ff || down_ready;
   assign load     = up_ready && up_valid;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // Rotate toward the x axis: the sign of y picks the direction.
   assign y_pos = !y_up[XY_WIDTH-1] && (y_up != '0);

   always_comb begin
      if (y_pos) begin
         x_in = x_up + (y_up >>> STAGE);
         y_in = y_up - (x_up >>> STAGE);
         z_in = z_up + ATAN;
      end else begin
         x_in = x_up - (y_up >>> STAGE);
         y_in = y_up + (x_up >>> STAGE);
         z_in = z_up - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         tag_ff <= tag_up;
      end
   end

   assign down_valid = valid_ff;
   assign x_down     = x_ff;
   assign y_down     = y_ff;
   assign z_down     = z_ff;
   assign tag_down   = tag_ff;

endmodule
